/* sv/prf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants of the prime residue filter coder
// prime table, segment offsets, field widths and the beat types that travel
// along the cell chain
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned NUM_W       = COUNT_W + 1;  // holds counts up to 127
  localparam int unsigned BITPOS_W    = 12;
  localparam int unsigned SEG_W       = 6;
  localparam int unsigned RES_W       = 8;
  localparam int unsigned PRIME_W     = 9;
  localparam int unsigned TABLE_SIZE  = 64;
  // byte-folded value stays below 4 * 255 * 310
  localparam int unsigned FOLD_W      = 19;
  // reciprocal shift, large enough for an exact quotient of a FOLD_W value
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned PROD_W      = FOLD_W + RECIP_SHIFT;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(37);

  localparam logic [PRIME_W-1:0] PRIMES [TABLE_SIZE] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  // element beat moving down the chain
  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [NUM_W-1:0]  cnt;   // primes in use for this element
  } token_t;

  // one sketch bit result
  typedef struct packed {
    logic [BITPOS_W-1:0] bit_position;
    logic [SEG_W-1:0]    segment_index;
    logic [RES_W-1:0]    residue;
    logic                last;
  } result_t;

  // start of segment idx: sum of all earlier primes
  function automatic int unsigned prime_offset(input int unsigned idx);
    int unsigned sum;
    sum = 0;
    for (int unsigned j = 0; j < idx; j++) begin
      sum = sum + int'(PRIMES[j]);
    end
    return sum;
  endfunction

endpackage

/* sv/prime_residue_filter_code.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_residue_filter_code: sketch bit generator over the leading primes
// encodes each element against primes 2, 3, 5, ... and emits one sketch bit
// position per prime in use
// ----------------------------------------------------------------------------
// An element is taken at a clock edge with start high and busy low. It then
// yields n results, n being the primes in use (prime_count capped at
// MAX_PRIMES), one per cycle in order of increasing prime; the final one has
// last_o set. Each result is shown for exactly one cycle with result_valid_o
// high and cannot be held off, so the receiver must take every beat. A new
// element can be taken while earlier ones are still in the row, and every
// cycle when n is 0 or 1; for a larger n, busy is raised after the accept
// so the single result port, one beat a cycle, never mixes two elements. The
// element travels down a row of MAX_PRIMES cells, one per cycle; cell i owns
// prime i and reduces the element modulo that prime in its own three stages.
// prime_count is written with prime_count_we_i and is meant to change only
// while no element is in flight; each element uses the count seen at accept.
// ----------------------------------------------------------------------------
module prime_residue_filter_code
  import prf_pkg::*;
#(
  parameter int unsigned MAX_PRIMES = 37
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                prime_count_we_i,
  input  logic [COUNT_W-1:0]  prime_count_i,
  // element command
  input  logic                start,
  output logic                busy,
  input  logic [ELEM_W-1:0]   element_i,
  // result beats
  output logic                result_valid_o,
  output logic [BITPOS_W-1:0] bit_position_o,
  output logic [SEG_W-1:0]    segment_index_o,
  output logic [RES_W-1:0]    residue_o,
  output logic                last_o
);

  logic [COUNT_W-1:0] prime_count_q;
  logic [NUM_W-1:0]   count_ext;
  logic [NUM_W-1:0]   n_eff;        // primes in use, capped
  logic [NUM_W-1:0]   wait_d, wait_q;
  logic               accept;

  logic                  tok_vld [MAX_PRIMES+1];
  token_t                tok     [MAX_PRIMES+1];
  logic [MAX_PRIMES-1:0] res_vld;
  result_t               res     [MAX_PRIMES];

  result_t sel;
  logic    out_vld_q;
  result_t out_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_count_q <= COUNT_RESET;
    end else if (prime_count_we_i) begin
      prime_count_q <= prime_count_i;
    end
  end

  always_comb begin
    count_ext = NUM_W'(prime_count_q);
    if (count_ext > NUM_W'(MAX_PRIMES)) begin
      n_eff = NUM_W'(MAX_PRIMES);
    end else begin
      n_eff = count_ext;
    end
  end

  // spacing counter: keeps result beats of successive elements apart
  assign accept = start && !busy;

  always_comb begin
    wait_d = wait_q;
    if (accept) begin
      if (n_eff == '0) begin
        wait_d = '0;
      end else begin
        wait_d = n_eff - NUM_W'(1);
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
    end else begin
      wait_q <= wait_d;
    end
  end

  assign busy = (wait_q != '0);

  // head of the chain
  assign tok_vld[0]  = accept;
  assign tok[0].elem = element_i;
  assign tok[0].cnt  = n_eff;

  for (genvar c = 0; c < MAX_PRIMES; c++) begin : g_cell
    prf_cell #(
      .IDX (c)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (tok_vld[c]),
      .tok_i     (tok[c]),
      .tok_vld_o (tok_vld[c+1]),
      .tok_o     (tok[c+1]),
      .res_vld_o (res_vld[c]),
      .res_o     (res[c])
    );
  end

  // at most one cell reports in any cycle, so an or-merge picks it
  always_comb begin
    sel = '0;
    for (int c = 0; c < MAX_PRIMES; c++) begin
      if (res_vld[c]) begin
        sel = sel | res[c];
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= |res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= sel;
  end

  assign result_valid_o  = out_vld_q;
  assign bit_position_o  = out_q.bit_position;
  assign segment_index_o = out_q.segment_index;
  assign residue_o       = out_q.residue;
  assign last_o          = out_q.last;

  // never two cells reporting at once
  a_one_cell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(res_vld))
    else $error("two cells report in the same cycle");

  // an element with more than one prime blocks the next start
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (n_eff > NUM_W'(1)) |=> busy)
    else $error("busy not raised after accept");

  // beats of one element come back to back with rising segment index
  a_segments_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      result_valid_o && (segment_index_o == $past(segment_index_o) + SEG_W'(1)))
    else $error("segment beats broken up or out of order");

  // the first segment starts at sketch bit zero
  a_first_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (segment_index_o == '0) |->
      bit_position_o == BITPOS_W'(residue_o))
    else $error("first segment bit not at its residue");

endmodule

/* sv/prf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_cell: one segment of the prime residue filter chain
// registers the element beat, hands it on, and reduces it modulo
// its own prime over three register stages
// ----------------------------------------------------------------------------
module prf_cell
  import prf_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    tok_vld_i,
  input  token_t  tok_i,
  output logic    tok_vld_o,
  output token_t  tok_o,
  output logic    res_vld_o,
  output result_t res_o
);

  localparam int unsigned Prime = int'(PRIMES[IDX]);
  // 256^k mod p for the byte fold
  localparam int unsigned C1 = 256 % Prime;
  localparam int unsigned C2 = 65536 % Prime;
  localparam int unsigned C3 = 16777216 % Prime;
  localparam int unsigned Recip = ((32'd1 << RECIP_SHIFT) + Prime - 1) / Prime;
  localparam logic [BITPOS_W-1:0] Offset = BITPOS_W'(prime_offset(IDX));
  localparam logic [NUM_W-1:0] IdxN  = NUM_W'(IDX);
  localparam logic [NUM_W-1:0] NextN = NUM_W'(IDX + 1);

  logic                tok_vld_q;
  token_t              tok_q;
  logic                v1_q, l1_q, v2_q, l2_q;
  logic [FOLD_W-1:0]   fold_d, fold_q, fold2_q;
  logic [PROD_W-1:0]   prod;
  logic [FOLD_W-1:0]   quo_d, quo_q;
  logic [FOLD_W-1:0]   rem_full;
  logic [PRIME_W-1:0]  rem;
  logic                res_vld_q;
  result_t             res_d, res_q;

  // fold the four bytes with their weights mod p
  always_comb begin
    fold_d = FOLD_W'(tok_q.elem[7:0])
           + FOLD_W'(tok_q.elem[15:8])  * FOLD_W'(C1)
           + FOLD_W'(tok_q.elem[23:16]) * FOLD_W'(C2)
           + FOLD_W'(tok_q.elem[31:24]) * FOLD_W'(C3);
  end

  // exact quotient by reciprocal
  assign prod  = PROD_W'(fold_q) * PROD_W'(Recip);
  assign quo_d = prod[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    rem_full            = fold2_q - quo_q * FOLD_W'(Prime);
    rem                 = rem_full[PRIME_W-1:0];
    res_d.bit_position  = Offset + BITPOS_W'(rem);
    res_d.segment_index = SEG_W'(IDX);
    res_d.residue       = rem[RES_W-1:0];
    res_d.last          = l2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      v1_q      <= tok_vld_q && (IdxN < tok_q.cnt);
      v2_q      <= v1_q;
      res_vld_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_i;
    l1_q    <= (tok_q.cnt == NextN);
    fold_q  <= fold_d;
    l2_q    <= l1_q;
    fold2_q <= fold_q;
    quo_q   <= quo_d;
    res_q   <= res_d;
  end

  // the beat dies past the last segment in use
  assign tok_vld_o = tok_vld_q && (NextN < tok_q.cnt);
  assign tok_o     = tok_q;
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

/* bench/prime_residue_filter_code_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_residue_filter_code_tb: self-checking bench for the prime residue coder
// drives element commands through start/busy, predicts the sketch bits of
// every element against the leading primes and checks each result beat in
// order, over several prime counts and sender idle rates
// ----------------------------------------------------------------------------
module prime_residue_filter_code_tb
  import prf_pkg::*;
();

  localparam int unsigned MAX_PRIMES   = 37;
  // drain wait, long enough for the last result of a full row to leave
  localparam int unsigned DRAIN_CYCLES = MAX_PRIMES + 8;
  // longest quiet stretch of a correct run is a drain pause plus a sender gap;
  // the limit takes it many times over
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RAND_PHASES  = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                prime_count_we_i;
  logic [COUNT_W-1:0]  prime_count_i;
  logic                start;
  logic                busy;
  logic [ELEM_W-1:0]   element_i;
  logic                result_valid_o;
  logic [BITPOS_W-1:0] bit_position_o;
  logic [SEG_W-1:0]    segment_index_o;
  logic [RES_W-1:0]    residue_o;
  logic                last_o;

  prime_residue_filter_code #(
    .MAX_PRIMES(MAX_PRIMES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prime_count_we_i(prime_count_we_i),
    .prime_count_i   (prime_count_i),
    .start           (start),
    .busy            (busy),
    .element_i       (element_i),
    .result_valid_o  (result_valid_o),
    .bit_position_o  (bit_position_o),
    .segment_index_o (segment_index_o),
    .residue_o       (residue_o),
    .last_o          (last_o)
  );

  // elements waiting for the driver, sketch bits waiting for the block
  logic [ELEM_W-1:0] pending_elems[$];
  result_t           sketch_bits_due[$];

  // mirror of the prime_count register, updated at the write edge
  logic [COUNT_W-1:0] count_mirror;

  int unsigned sender_idle_pct;
  logic        elem_taken;   // element beat accepted at the last rising edge
  logic        quiet;        // nothing queued, nothing presented, nothing due
  int unsigned quiet_cycles;
  int unsigned fails;
  int unsigned elems_sent;
  int unsigned bits_checked;
  int unsigned count_writes;

  // clock: 10 ns period
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // expected sketch bits of one element under a given prime count
  function automatic void encode_element(input logic [ELEM_W-1:0] value,
                                         input logic [COUNT_W-1:0] count);
    int unsigned in_use;
    int unsigned seg_base;
    int unsigned rem;
    int unsigned p;
    result_t     entry;
    // counts above the row length fall back to the full row
    in_use   = (count > MAX_PRIMES) ? MAX_PRIMES : count;
    seg_base = 0;
    for (int unsigned i = 0; i < in_use; i++) begin
      p                   = PRIMES[i];
      rem                 = value % p;
      entry.bit_position  = BITPOS_W'(seg_base + rem);
      entry.segment_index = SEG_W'(i);
      entry.residue       = RES_W'(rem);
      entry.last          = (i + 1 == in_use);
      sketch_bits_due.push_back(entry);
      seg_base += p;
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // driver: a new element goes up at the falling edge once the last one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || elem_taken)) begin
      if (pending_elems.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start     <= 1'b1;
        element_i <= pending_elems.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks result beats, predicts on element beats, tracks the register
  always @(posedge clk_i) begin
    result_t want;
    logic    elem_beat;
    elem_beat = rst_ni && start && !busy;
    if (rst_ni && result_valid_o) begin
      if (sketch_bits_due.size() == 0) begin
        $error("unexpected result beat: bit_position %0d segment %0d",
               bit_position_o, segment_index_o);
        fails++;
      end else begin
        want = sketch_bits_due.pop_front();
        check_field("bit_position", want.bit_position, bit_position_o);
        check_field("segment_index", want.segment_index, segment_index_o);
        check_field("residue", want.residue, residue_o);
        check_field("last", want.last, last_o);
        bits_checked++;
      end
    end
    if (elem_beat) begin
      encode_element(element_i, count_mirror);
      elems_sent++;
    end
    if (rst_ni && prime_count_we_i) begin
      count_mirror = prime_count_i;
    end
    elem_taken <= elem_beat;
    quiet      <= (pending_elems.size() == 0) && !start && (sketch_bits_due.size() == 0);
    // watchdog on cycles with neither an element nor a result beat
    if (rst_ni) begin
      if (elem_beat || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // block until everything queued has gone in and every due bit has come out
  task automatic wait_drained();
    @(posedge clk_i);
    do @(negedge clk_i); while (!quiet);
  endtask

  // register write only with the block idle; count-zero elements leave no
  // result behind, so give the row its full latency first
  task automatic set_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    prime_count_we_i <= 1'b1;
    prime_count_i    <= value;
    @(negedge clk_i);
    prime_count_we_i <= 1'b0;
    count_writes++;
    // queue fills happen at a rising edge, away from the driver
    @(posedge clk_i);
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_count [RAND_PHASES];
    int unsigned        phase_items [RAND_PHASES];
    int unsigned        idle_steps [3];
    logic [ELEM_W-1:0]  value;

    phase_count = '{6'd37, 6'd63, 6'd1, 6'd0, 6'd20, 6'd2, 6'd36, 6'd0};
    phase_items = '{60, 56, 60, 24, 60, 60, 56, 56};
    idle_steps  = '{0, 71, 37};
    // last phase uses a random count, never zero
    phase_count[RAND_PHASES-1] = COUNT_W'($urandom_range(1, 63));

    rst_ni           = 1'b0;
    start            <= 1'b0;
    element_i        <= '0;
    prime_count_we_i <= 1'b0;
    prime_count_i    <= '0;
    sender_idle_pct  = 0;
    count_mirror     = COUNT_RESET;
    elem_taken       <= 1'b0;
    quiet            <= 1'b0;
    quiet_cycles     = 0;
    fails            = 0;
    elems_sent       = 0;
    bits_checked     = 0;
    count_writes     = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: reset count, element extremes, all-zero residues over the
    // first nine primes, largest residue of the last prime, largest bit index
    pending_elems.push_back(32'h0000_0000);
    pending_elems.push_back(32'hFFFF_FFFF);
    pending_elems.push_back(32'h0000_0001);
    pending_elems.push_back(32'h8000_0000);
    pending_elems.push_back(32'h7FFF_FFFF);
    pending_elems.push_back(32'd223092870);
    pending_elems.push_back(32'd156);
    pending_elems.push_back(32'd2583);
    pending_elems.push_back(32'hAAAA_AAAA);
    pending_elems.push_back(32'h5555_5555);
    pending_elems.push_back(32'hFFFF_FFFE);
    pending_elems.push_back(32'd1000000007);

    // zero prime count: elements go in, nothing comes out
    set_count(6'd0);
    pending_elems.push_back(32'h0000_0000);
    pending_elems.push_back(32'hFFFF_FFFF);
    pending_elems.push_back(32'h1234_5678);

    // single prime: back-to-back accepts
    set_count(6'd1);
    pending_elems.push_back(32'h0000_0000);
    pending_elems.push_back(32'hFFFF_FFFF);
    pending_elems.push_back(32'h0000_0003);

    // counts past the row length clamp to the full row
    set_count(6'd63);
    pending_elems.push_back(32'hFFFF_FFFF);
    pending_elems.push_back(32'd156);
    pending_elems.push_back(32'hDEAD_BEEF);
    set_count(6'd38);
    pending_elems.push_back(32'h0000_0000);
    pending_elems.push_back(32'hCAFE_F00D);

    // random phases, cycling the sender idle rate
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      set_count(phase_count[ph]);
      sender_idle_pct = idle_steps[ph % 3];
      for (int unsigned k = 0; k < phase_items[ph]; k++) begin
        case ($urandom_range(0, 3))
          0:       value = ELEM_W'($urandom_range(0, 1000));
          1:       value = 32'hFFFF_FFFF - ELEM_W'($urandom_range(0, 1000));
          default: value = $urandom;
        endcase
        pending_elems.push_back(value);
        // halfway through one phase the sender holds off until all bits are in
        if (ph == 2 && k == phase_items[ph] / 2) begin
          wait_drained();
          @(posedge clk_i);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sketch_bits_due.size() != 0) begin
      $error("%0d sketch bits never arrived", sketch_bits_due.size());
      fails++;
    end

    $display("covered %0d elements and %0d sketch bits over %0d prime count writes,",
             elems_sent, bits_checked, count_writes);
    $display("counts 0 to 63 with clamping, sender idle at 0, 37 and 71 percent");
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
